// ===== rtl/core/rbap_pkg.sv =====
// rbap_pkg: shared constants, result codes and result types of the RESP
// bulk array parser. No dependencies; used by every file under rtl/core.

package rbap_pkg;

   // Signed width that header and count numbers must fit in
   localparam int NUM_WIDTH   = 32;
   // Width of the reported token index (saturating)
   localparam int INDEX_WIDTH = 31;
   // Accepted-token counter: wide enough to exceed any legal count and the index range
   localparam int CNT_WIDTH   = ((NUM_WIDTH > INDEX_WIDTH) ? NUM_WIDTH : INDEX_WIDTH) + 1;

   // Result queue; depth must be a power of two so the pointers wrap
   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_PUSH    = 3;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_HT     = 8'h09;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;

   typedef enum logic [1:0] {
      KIND_PAYLOAD,
      KIND_ACCEPT,
      KIND_DISCARD,
      KIND_STATUS
   } rbap_kind_type;

   typedef enum logic [2:0] {
      STATUS_OK,
      STATUS_BAD_HEADER,
      STATUS_NO_PAYLOAD,
      STATUS_BAD_NUMBER,
      STATUS_COUNT_MISMATCH
   } rbap_status_type;

   typedef struct packed {
      rbap_kind_type          kind;
      logic [7:0]             data_byte;
      logic [INDEX_WIDTH-1:0] token_index;
      rbap_status_type        status;
      logic                   last;
   } rbap_result_type;

   // Up to three results per request, in order: payload, token, status
   typedef struct packed {
      logic [MAX_PUSH-1:0]            valid;
      rbap_result_type [MAX_PUSH-1:0] item;
   } rbap_push_type;

endpackage

// ===== rtl/core/rbap_result_queue.sv =====
// rbap_result_queue: small in-order queue; takes up to three results per cycle
// and hands out one per cycle while rsp_ready is high. Depends on rbap_pkg.

module rbap_result_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  rbap_pkg::rbap_push_type  push,
   output logic                     room,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rbap_pkg::rbap_result_type rsp_item
);

   typedef logic [rbap_pkg::QPTR_WIDTH-1:0] qptr_type;
   typedef logic [rbap_pkg::QCNT_WIDTH-1:0] qcnt_type;

   rbap_pkg::rbap_result_type entry_ff [rbap_pkg::QUEUE_DEPTH];
   qptr_type head_ff, head_in;
   qptr_type tail_ff, tail_in;
   qcnt_type count_ff, count_in;
   qptr_type slot_pos [rbap_pkg::MAX_PUSH];
   qcnt_type push_count;
   logic     pop;

   assign pop       = (count_ff != '0) && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_item  = entry_ff[head_ff];
   // room for a worst-case request
   assign room      = (count_ff <= qcnt_type'(rbap_pkg::QUEUE_DEPTH - rbap_pkg::MAX_PUSH));

   // pack the valid slots behind the tail in order
   always_comb begin
      push_count = '0;
      for (int i = 0; i < rbap_pkg::MAX_PUSH; i++) begin
         slot_pos[i] = tail_ff + qptr_type'(push_count);
         push_count  = push_count + qcnt_type'(push.valid[i]);
      end
      tail_in  = tail_ff + qptr_type'(push_count);
      head_in  = head_ff + qptr_type'(pop);
      count_in = count_ff + push_count - qcnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < rbap_pkg::MAX_PUSH; i++) begin
         if (push.valid[i]) begin
            entry_ff[slot_pos[i]] <= push.item[i];
         end
      end
   end

endmodule

// ===== rtl/core/rbap_parser.sv =====
// rbap_parser: input register and one-byte parse step of the RESP request
// frame; produces up to three results per request. Depends on rbap_pkg.

module rbap_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_in_byte,
   input  logic                    req_frame_end,
   input  logic                    room,
   output rbap_pkg::rbap_push_type push
);

   localparam int NW = rbap_pkg::NUM_WIDTH;
   localparam int CW = rbap_pkg::CNT_WIDTH;
   localparam int IW = rbap_pkg::INDEX_WIDTH;

   typedef enum logic [1:0] {
      LINE_COUNT,
      LINE_HEADER,
      LINE_PAYLOAD
   } line_kind_type;

   typedef enum logic [1:0] {
      PH_BEFORE,
      PH_SIGN,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      line_kind_type             line_kind;
      logic [NW-1:0]             line_chars;
      phase_type                 phase;
      logic                      negative;
      logic [NW-1:0]             value;
      logic [NW-1:0]             exp_args;
      logic                      args_neg;
      logic [NW-1:0]             exp_len;
      logic                      len_neg;
      logic [CW-1:0]             accepted;
      rbap_pkg::rbap_status_type error;
   } pstate_type;

   localparam pstate_type RESET_STATE = '{
      line_kind: LINE_COUNT,
      phase:     PH_BEFORE,
      error:     rbap_pkg::STATUS_OK,
      default:   '0
   };

   function automatic logic [IW-1:0] sat_index(logic [CW-1:0] acc);
      return (|acc[CW-1:IW]) ? {IW{1'b1}} : acc[IW-1:0];
   endfunction

   // one character of a decimal number: blanks, sign, digits, then anything
   function automatic pstate_type num_feed(pstate_type s, logic [7:0] c);
      pstate_type    r;
      logic          digit;
      logic          accumulate;
      logic [NW+3:0] lim;
      logic [NW+3:0] nxt;
      r          = s;
      accumulate = 1'b0;
      digit      = (c >= rbap_pkg::CHAR_ZERO) && (c <= rbap_pkg::CHAR_NINE);
      lim        = {{4{1'b0}}, 1'b1, {(NW-1){1'b0}}} - {{(NW+3){1'b0}}, ~s.negative};
      nxt        = {1'b0, s.value, 3'b000} + {3'b000, s.value, 1'b0} + {{NW{1'b0}}, c[3:0]};
      case (s.phase)
         PH_BEFORE: begin
            if (c == rbap_pkg::CHAR_SPACE || c == rbap_pkg::CHAR_HT ||
                c == rbap_pkg::CHAR_VT || c == rbap_pkg::CHAR_FF) begin
               r.phase = PH_BEFORE;
            end else if (c == rbap_pkg::CHAR_PLUS || c == rbap_pkg::CHAR_MINUS) begin
               r.negative = (c == rbap_pkg::CHAR_MINUS);
               r.phase    = PH_SIGN;
            end else if (!digit) begin
               r.error = rbap_pkg::STATUS_BAD_NUMBER;
            end else begin
               accumulate = 1'b1;
            end
         end
         PH_SIGN: begin
            if (!digit) r.error = rbap_pkg::STATUS_BAD_NUMBER;
            else        accumulate = 1'b1;
         end
         PH_DIGITS: begin
            if (!digit) r.phase = PH_DONE;
            else        accumulate = 1'b1;
         end
         default: begin
            r.phase = s.phase;
         end
      endcase
      if (accumulate) begin
         r.phase = PH_DIGITS;
         if (nxt > lim) r.error = rbap_pkg::STATUS_BAD_NUMBER;
         else           r.value = nxt[NW-1:0];
      end
      return r;
   endfunction

   // one character that is neither LF nor CR
   function automatic pstate_type feed_char(pstate_type s, logic [7:0] c,
                                            output logic emit_payload);
      pstate_type r;
      logic       skip;
      r            = s;
      skip         = 1'b0;
      emit_payload = 1'b0;
      case (s.line_kind)
         LINE_COUNT: begin
            if (s.line_chars == '0) begin
               r.phase    = (c == rbap_pkg::CHAR_STAR) ? PH_BEFORE : PH_DONE;
               r.negative = 1'b0;
               r.value    = '0;
            end else begin
               r = num_feed(s, c);
            end
         end
         LINE_HEADER: begin
            if (s.line_chars == '0) begin
               if (c != rbap_pkg::CHAR_DOLLAR) begin
                  r.error = rbap_pkg::STATUS_BAD_HEADER;
                  skip    = 1'b1;
               end else begin
                  r.phase    = PH_BEFORE;
                  r.negative = 1'b0;
                  r.value    = '0;
               end
            end else begin
               r = num_feed(s, c);
            end
         end
         default: begin
            emit_payload = 1'b1;
         end
      endcase
      if (!skip && r.line_chars != '1) r.line_chars = r.line_chars + 1'b1;
      return r;
   endfunction

   // close the current line; a payload line yields a token result
   function automatic pstate_type end_line(pstate_type s, output logic tok_valid,
                                           output rbap_pkg::rbap_kind_type tok_kind);
      pstate_type r;
      logic       keep;
      logic       bad_num;
      r         = s;
      keep      = 1'b0;
      tok_valid = 1'b0;
      tok_kind  = rbap_pkg::KIND_ACCEPT;
      bad_num   = (s.phase == PH_BEFORE) || (s.phase == PH_SIGN);
      case (s.line_kind)
         LINE_COUNT: begin
            if (s.line_chars != '0 && bad_num) begin
               r.error = rbap_pkg::STATUS_BAD_NUMBER;
               keep    = 1'b1;
            end else begin
               if (s.line_chars != '0) begin
                  r.exp_args = s.value;
                  r.args_neg = s.negative && (s.value != '0);
               end
               r.line_kind = LINE_HEADER;
            end
         end
         LINE_HEADER: begin
            if (s.line_chars == '0) begin
               r.error = rbap_pkg::STATUS_BAD_HEADER;
               keep    = 1'b1;
            end else if (bad_num) begin
               r.error = rbap_pkg::STATUS_BAD_NUMBER;
               keep    = 1'b1;
            end else begin
               r.exp_len   = s.value;
               r.len_neg   = s.negative && (s.value != '0);
               r.line_kind = LINE_PAYLOAD;
            end
         end
         default: begin
            tok_valid = 1'b1;
            if (!s.len_neg && s.line_chars == s.exp_len) begin
               tok_kind = rbap_pkg::KIND_ACCEPT;
               if (s.accepted != '1) r.accepted = s.accepted + 1'b1;
            end else begin
               tok_kind = rbap_pkg::KIND_DISCARD;
            end
            r.line_kind = LINE_HEADER;
         end
      endcase
      if (!keep) r.line_chars = '0;
      return r;
   endfunction

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_end_ff, in_end_in;
   pstate_type state_ff, state_in;
   logic       consume;

   logic                    pay_v;
   logic                    tok_a_v, tok_b_v;
   rbap_pkg::rbap_kind_type tok_a_k, tok_b_k;
   logic [IW-1:0]           tok_index;
   pstate_type              s;

   assign consume   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      in_byte_in  = (req_valid && req_ready) ? req_in_byte : in_byte_ff;
      in_end_in   = (req_valid && req_ready) ? req_frame_end : in_end_ff;
   end

   always_comb begin
      s       = state_ff;
      pay_v   = 1'b0;
      tok_a_v = 1'b0;
      tok_b_v = 1'b0;
      tok_a_k = rbap_pkg::KIND_ACCEPT;
      tok_b_k = rbap_pkg::KIND_ACCEPT;
      if (s.error == rbap_pkg::STATUS_OK) begin
         if (in_byte_ff == rbap_pkg::CHAR_LF) begin
            s = end_line(s, tok_a_v, tok_a_k);
         end else if (in_byte_ff != rbap_pkg::CHAR_CR) begin
            s = feed_char(s, in_byte_ff, pay_v);
         end
      end
      // token index is taken after this byte's step, before the frame-end close moves the count
      tok_index = sat_index(s.accepted);
      if (in_end_ff) begin
         if (s.error == rbap_pkg::STATUS_OK && s.line_chars != '0) begin
            s = end_line(s, tok_b_v, tok_b_k);
         end
         if (s.error == rbap_pkg::STATUS_OK && s.line_kind == LINE_PAYLOAD) begin
            s.error = rbap_pkg::STATUS_NO_PAYLOAD;
         end
         if (s.error == rbap_pkg::STATUS_OK &&
             (s.args_neg || {{(CW-NW){1'b0}}, s.exp_args} != s.accepted)) begin
            s.error = rbap_pkg::STATUS_COUNT_MISMATCH;
         end
      end

      push.valid[0] = consume && pay_v;
      push.item[0]  = '{kind: rbap_pkg::KIND_PAYLOAD, data_byte: in_byte_ff,
                        token_index: sat_index(state_ff.accepted),
                        status: rbap_pkg::STATUS_OK, last: 1'b0};
      push.valid[1] = consume && (tok_a_v || tok_b_v);
      push.item[1]  = '{kind: (tok_a_v ? tok_a_k : tok_b_k), data_byte: 8'h00,
                        token_index: tok_a_v ? sat_index(state_ff.accepted) : tok_index,
                        status: rbap_pkg::STATUS_OK, last: 1'b0};
      push.valid[2] = consume && in_end_ff;
      push.item[2]  = '{kind: rbap_pkg::KIND_STATUS, data_byte: 8'h00,
                        token_index: sat_index(s.accepted),
                        status: s.error, last: 1'b1};

      if (!consume)       state_in = state_ff;
      else if (in_end_ff) state_in = RESET_STATE;
      else                state_in = s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= RESET_STATE;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_end_ff  <= in_end_in;
   end

endmodule

// ===== rtl/core/resp_bulk_array_parser.sv =====
// resp_bulk_array_parser: one request per cycle in while req_ready is high;
// results leave one per cycle from a 4-entry queue while rsp_ready is high.
// The first result of a request shows on rsp_* after the input register has
// passed it into the queue. Sustained rate: one request per cycle while each
// makes at most one result and rsp_ready stays high; one that makes two (a
// token and the status), or a payload byte that ends the frame and makes
// three, holds the input until the queue has room again. Synchronous reset
// clears the parse state, the input register and the queue; results then start empty.

module resp_bulk_array_parser (
   input  logic        clock,
   input  logic        reset,
   // request channel: one frame byte per request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_end,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [30:0] rsp_token_index,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);

   rbap_pkg::rbap_push_type   push;
   rbap_pkg::rbap_result_type rsp_item;
   logic                      room;

   // Parse step: hold the request in the input register until the queue has
   // room for the worst case, then advance the line/number state and emit
   // payload, token and status results for that byte.
   rbap_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_frame_end (req_frame_end),
      .room          (room),
      .push          (push)
   );

   // Result queue: keep results in order and drain one per accepted response.
   rbap_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // Split the head entry onto the response ports.
   assign rsp_kind        = rsp_item.kind;
   assign rsp_data_byte   = rsp_item.data_byte;
   assign rsp_token_index = rsp_item.token_index;
   assign rsp_status      = rsp_item.status;
   assign rsp_last        = rsp_item.last;

endmodule

// ===== test/resp_frame_checker.sv =====
// resp_frame_checker: watches the request and result channels of the RESP bulk
// array parser, predicts every result from the accepted bytes and compares.
// Depends on rbap_pkg for result codes, characters and the result struct.

module resp_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_frame_end,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic [30:0] rsp_token_index,
   input  logic [2:0]  rsp_status,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [1:0] {LINE_COUNT, LINE_HEADER, LINE_PAYLOAD} line_role_type;
   typedef enum logic [1:0] {NUM_BEFORE, NUM_SIGN, NUM_DIGITS, NUM_DONE} num_phase_type;

   localparam longint unsigned INDEX_MAX = (64'd1 << rbap_pkg::INDEX_WIDTH) - 1;

   line_role_type             line_role;
   longint unsigned           line_len;
   num_phase_type             num_phase;
   bit                        num_neg;
   longint unsigned           num_val;
   longint unsigned           args_want;
   bit                        args_neg;
   longint unsigned           len_want;
   bit                        len_neg;
   longint unsigned           tokens_ok;
   rbap_pkg::rbap_status_type frame_err;

   rbap_pkg::rbap_result_type results_due[$];

   task automatic start_number();
      num_phase = NUM_BEFORE;
      num_neg   = 1'b0;
      num_val   = 0;
   endtask

   task automatic clear_parse();
      line_role = LINE_COUNT;
      line_len  = 0;
      start_number();
      args_want = 0;
      args_neg  = 1'b0;
      len_want  = 0;
      len_neg   = 1'b0;
      tokens_ok = 0;
      frame_err = rbap_pkg::STATUS_OK;
   endtask

   task automatic push_result(input rbap_pkg::rbap_kind_type kind, input logic [7:0] data,
                              input rbap_pkg::rbap_status_type status, input logic last);
      rbap_pkg::rbap_result_type r;
      r.kind        = kind;
      r.data_byte   = data;
      r.token_index = (tokens_ok > INDEX_MAX) ? INDEX_MAX[rbap_pkg::INDEX_WIDTH-1:0]
                                              : tokens_ok[rbap_pkg::INDEX_WIDTH-1:0];
      r.status      = status;
      r.last        = last;
      results_due   = {results_due, r};
   endtask

   // stoi-like number: blanks, optional sign, digits, then anything
   task automatic feed_number(input logic [7:0] c);
      bit              is_digit;
      longint unsigned d;
      longint unsigned lim;
      is_digit = (c >= rbap_pkg::CHAR_ZERO) && (c <= rbap_pkg::CHAR_NINE);
      d        = c - rbap_pkg::CHAR_ZERO;
      if (num_phase == NUM_DONE) return;
      if (num_phase == NUM_DIGITS && !is_digit) begin
         num_phase = NUM_DONE;
         return;
      end
      if (num_phase == NUM_BEFORE &&
          (c == rbap_pkg::CHAR_SPACE || c == rbap_pkg::CHAR_HT ||
           c == rbap_pkg::CHAR_VT || c == rbap_pkg::CHAR_FF)) return;
      if (num_phase == NUM_BEFORE &&
          (c == rbap_pkg::CHAR_PLUS || c == rbap_pkg::CHAR_MINUS)) begin
         num_neg   = (c == rbap_pkg::CHAR_MINUS);
         num_phase = NUM_SIGN;
         return;
      end
      if (!is_digit) begin
         frame_err = rbap_pkg::STATUS_BAD_NUMBER;
         return;
      end
      num_phase = NUM_DIGITS;
      lim = (64'd1 << (rbap_pkg::NUM_WIDTH - 1)) - (num_neg ? 64'd0 : 64'd1);
      if (num_val > (lim - d) / 10) begin
         frame_err = rbap_pkg::STATUS_BAD_NUMBER;
         return;
      end
      num_val = num_val * 10 + d;
   endtask

   task automatic close_line();
      case (line_role)
         LINE_COUNT: begin
            if (line_len != 0) begin
               if (num_phase == NUM_BEFORE || num_phase == NUM_SIGN) begin
                  frame_err = rbap_pkg::STATUS_BAD_NUMBER;
                  return;
               end
               args_want = num_val;
               args_neg  = num_neg && (num_val != 0);
            end
            line_role = LINE_HEADER;
         end
         LINE_HEADER: begin
            if (line_len == 0) begin
               frame_err = rbap_pkg::STATUS_BAD_HEADER;
               return;
            end
            if (num_phase == NUM_BEFORE || num_phase == NUM_SIGN) begin
               frame_err = rbap_pkg::STATUS_BAD_NUMBER;
               return;
            end
            len_want  = num_val;
            len_neg   = num_neg && (num_val != 0);
            line_role = LINE_PAYLOAD;
         end
         default: begin
            if (!len_neg && line_len == len_want) begin
               push_result(rbap_pkg::KIND_ACCEPT, 8'h00, rbap_pkg::STATUS_OK, 1'b0);
               if (tokens_ok != '1) tokens_ok++;
            end else begin
               push_result(rbap_pkg::KIND_DISCARD, 8'h00, rbap_pkg::STATUS_OK, 1'b0);
            end
            line_role = LINE_HEADER;
         end
      endcase
      line_len = 0;
   endtask

   task automatic parse_request(input logic [7:0] c, input logic frame_end);
      if (frame_err == rbap_pkg::STATUS_OK) begin
         if (c == rbap_pkg::CHAR_LF) begin
            close_line();
         end else if (c != rbap_pkg::CHAR_CR) begin
            case (line_role)
               LINE_COUNT: begin
                  if (line_len == 0) begin
                     start_number();
                     if (c != rbap_pkg::CHAR_STAR) num_phase = NUM_DONE;
                  end else begin
                     feed_number(c);
                  end
               end
               LINE_HEADER: begin
                  if (line_len == 0) begin
                     if (c != rbap_pkg::CHAR_DOLLAR) frame_err = rbap_pkg::STATUS_BAD_HEADER;
                     else start_number();
                  end else begin
                     feed_number(c);
                  end
               end
               default: push_result(rbap_pkg::KIND_PAYLOAD, c, rbap_pkg::STATUS_OK, 1'b0);
            endcase
            if (line_len != '1) line_len++;
         end
      end
      if (frame_end) begin
         if (frame_err == rbap_pkg::STATUS_OK && line_len > 0) close_line();
         if (frame_err == rbap_pkg::STATUS_OK && line_role == LINE_PAYLOAD)
            frame_err = rbap_pkg::STATUS_NO_PAYLOAD;
         if (frame_err == rbap_pkg::STATUS_OK && (args_neg || args_want != tokens_ok))
            frame_err = rbap_pkg::STATUS_COUNT_MISMATCH;
         push_result(rbap_pkg::KIND_STATUS, 8'h00, frame_err, 1'b1);
         clear_parse();
      end
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rbap_pkg::rbap_result_type want;
      if (reset) begin
         results_due.delete();
         clear_parse();
      end else begin
         // compare before predicting: a result never leaves in its request's cycle
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: unexpected result kind=%0d data=%0h index=%0d status=%0d last=%0b",
                        $time, rsp_kind, rsp_data_byte, rsp_token_index, rsp_status,
                        rsp_last);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               compare_field("kind", want.kind, rsp_kind);
               compare_field("data_byte", want.data_byte, rsp_data_byte);
               compare_field("token_index", want.token_index, rsp_token_index);
               compare_field("status", want.status, rsp_status);
               compare_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && req_ready) parse_request(req_in_byte, req_frame_end);
      end
      pending = results_due.size();
   end

endmodule

// ===== test/tb_resp_bulk_array_parser.sv =====
// tb_resp_bulk_array_parser: drives RESP request frames byte by byte into the
// parser under random idling on both channels and gives the verdict.
// Depends on rbap_pkg, resp_bulk_array_parser and resp_frame_checker.

module tb_resp_bulk_array_parser;

   timeunit 1ns;
   timeprecision 1ps;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte   = 8'h00;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [30:0] rsp_token_index;
   logic [2:0]  rsp_status;
   logic        rsp_last;

   int fail_count;
   int pending;

   // bytes of the frame being built, sent in order with frame_end on the last
   logic [7:0] frame_q[$];
   int         sent_count = 0;
   bit         burst      = 1'b0;

   // receiver stall state
   int stall_left = 0;
   int rsp_cycles = 0;
   bit rsp_steady = 1'b0;

   always #5 clock = ~clock;

   resp_bulk_array_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_token_index (rsp_token_index),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   resp_frame_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_token_index (rsp_token_index),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // append one byte to the frame under construction
   task automatic add_byte(input logic [7:0] b);
      frame_q = {frame_q, b};
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   // Line end: mostly CR LF, sometimes a bare LF, sometimes an extra CR.
   task automatic put_eol();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         add_byte(rbap_pkg::CHAR_LF);
      end else if (sel == 1) begin
         add_byte(rbap_pkg::CHAR_CR);
         add_byte(rbap_pkg::CHAR_CR);
         add_byte(rbap_pkg::CHAR_LF);
      end else begin
         add_byte(rbap_pkg::CHAR_CR);
         add_byte(rbap_pkg::CHAR_LF);
      end
   endtask

   // Decimal number, usually plain; sometimes with blanks, a plus sign,
   // trailing junk, or replaced by a limit, overflow or malformed value.
   task automatic put_number(input int value);
      int    sel;
      string digits;
      sel    = $urandom_range(0, 99);
      digits = $sformatf("%0d", value);
      if (sel < 6) begin
         repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 3))
               0:       add_byte(rbap_pkg::CHAR_SPACE);
               1:       add_byte(rbap_pkg::CHAR_HT);
               2:       add_byte(rbap_pkg::CHAR_VT);
               default: add_byte(rbap_pkg::CHAR_FF);
            endcase
         end
      end else if (sel < 10 && value >= 0) begin
         add_byte(rbap_pkg::CHAR_PLUS);
      end else if (sel < 16) begin
         case ($urandom_range(0, 9))
            0:       digits = "2147483647";
            1:       digits = "2147483648";
            2:       digits = "-2147483648";
            3:       digits = "-2147483649";
            4:       digits = "-0";
            5:       digits = "99999999999";
            6:       digits = "";
            7:       digits = "+";
            8:       digits = "-x";
            default: digits = "-1";
         endcase
      end
      put_text(digits);
      if (sel >= 16 && sel < 19) begin
         if ($urandom_range(0, 1) != 0) put_text("x");
         else put_text(" 7");
      end
   endtask

   // Build one random frame: mostly well-formed arrays of bulk strings with
   // random content, some with wrong counts or lengths, some cut short, and
   // some plain noise.
   task automatic build_frame();
      int         shape;
      int         n_args;
      int         want_args;
      int         len_i;
      int         cut;
      logic [7:0] b;
      frame_q.delete();
      shape = $urandom_range(0, 99);
      if (shape < 12) begin
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         n_args    = $urandom_range(0, 3);
         want_args = n_args;
         if ($urandom_range(0, 9) == 0)
            want_args = n_args + (($urandom_range(0, 1) != 0) ? 1 : -1);
         if ($urandom_range(0, 19) == 0) begin
            put_text("ping");
            put_eol();
         end else begin
            add_byte(rbap_pkg::CHAR_STAR);
            put_number(want_args);
            put_eol();
         end
         for (int i = 0; i < n_args; i++) begin
            len_i = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20)
                                                : $urandom_range(0, 6);
            if ($urandom_range(0, 19) == 0) add_byte(8'($urandom_range(0, 255)));
            else add_byte(rbap_pkg::CHAR_DOLLAR);
            if ($urandom_range(0, 11) == 0)
               put_number(len_i + (($urandom_range(0, 1) != 0) ? 1 : -1));
            else
               put_number(len_i);
            put_eol();
            repeat (len_i) begin
               b = 8'($urandom_range(0, 255));
               // keep most payloads free of line breaks
               if ((b == rbap_pkg::CHAR_LF || b == rbap_pkg::CHAR_CR) &&
                   $urandom_range(0, 7) != 0)
                  b = b ^ 8'h40;
               add_byte(b);
            end
            if (i != n_args - 1 || $urandom_range(0, 1) != 0) put_eol();
         end
         if (shape < 30 && frame_q.size() > 1) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut) void'(frame_q.pop_back());
         end
      end
      if (frame_q.size() == 0) add_byte(8'($urandom_range(0, 255)));
   endtask

   // Send the frame one request per byte; enter and leave at a falling edge.
   task automatic send_frame();
      int gap;
      foreach (frame_q[i]) begin
         req_valid     <= 1'b1;
         req_in_byte   <= frame_q[i];
         req_frame_end <= (i == frame_q.size() - 1);
         // hold the request until the parser takes it
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         sent_count++;
         @(negedge clock);
         gap = burst ? 0 : pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Result side: random stalls, with stretches of steady ready.
   always @(negedge clock) begin
      rsp_cycles++;
      if (rsp_cycles % 150 == 0) rsp_steady = ($urandom_range(0, 3) == 0);
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!rsp_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: frame of only a CR, so the count defaults to zero
      frame_q.delete();
      add_byte(rbap_pkg::CHAR_CR);
      send_frame();
      // count line with a star and no digits
      frame_q.delete();
      put_text("*");
      send_frame();
      // empty count line, then a header that does not start with a dollar
      frame_q.delete();
      add_byte(rbap_pkg::CHAR_LF);
      add_byte(8'h00);
      send_frame();
      // header as the last line: missing payload
      frame_q.delete();
      put_text("\n$1");
      send_frame();
      // negative count
      frame_q.delete();
      put_text("*-1");
      send_frame();
      // negative length: token discarded, frame still fine
      frame_q.delete();
      put_text("\n$-1\nz");
      send_frame();
      // unterminated one-byte payload ending the frame: byte, token, status
      frame_q.delete();
      put_text("*1\n$1\n");
      add_byte(8'hFF);
      send_frame();

      // random frames until enough bytes have gone in
      while (sent_count < 460) begin
         burst = ($urandom_range(0, 4) == 0);
         build_frame();
         send_frame();
      end
      req_valid <= 1'b0;

      // drain: wait for every result, then a few more cycles for strays
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[resp_bulk_array_parser] OK");
      end else begin
         $display("[resp_bulk_array_parser] ERROR");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("[resp_bulk_array_parser] ERROR");
      $finish;
   end

endmodule
